// ===== hw/rtl/tlik_pkg.sv =====
package tlik_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int XW = 36;
  localparam int ZW = 34;

  localparam logic [1:0] CFG_FIRST_LINK  = 2'd0;
  localparam logic [1:0] CFG_SECOND_LINK = 2'd1;
  localparam logic [1:0] CFG_ANGLE_SCALE = 2'd2;

  localparam logic signed [ZW-1:0] PI_HALF_Q30 = 34'sd1686629713;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef logic [1:0] cfg_index_t;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] angle_plus;
    logic signed [31:0] angle_minus;
    logic               out_of_reach;
  } out_data_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [33:0] n;
    logic               szero;
  } sq1_side_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               szero;
    logic               dzero;
    logic               beyond;
    logic               npos;
    logic               nneg;
  } div_side_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] cosv;
    logic               flag;
  } sq2_side_t;

  function automatic logic [ZW-1:0] atan_q30(input int i);
    logic [ZW-1:0] v;
    case (i)
      0:  v = 34'h3243F6A8;
      1:  v = 34'h1DAC6705;
      2:  v = 34'h0FADBAFC;
      3:  v = 34'h07F56EA6;
      4:  v = 34'h03FEAB76;
      5:  v = 34'h01FFD55B;
      6:  v = 34'h00FFFAAA;
      7:  v = 34'h007FFF55;
      8:  v = 34'h003FFFEA;
      9:  v = 34'h001FFFFD;
      10: v = 34'h000FFFFF;
      11: v = 34'h0007FFFF;
      12: v = 34'h0003FFFF;
      13: v = 34'h0001FFFF;
      14: v = 34'h0000FFFF;
      15: v = 34'h00007FFF;
      16: v = 34'h00003FFF;
      17: v = 34'h00001FFF;
      18: v = 34'h00000FFF;
      19: v = 34'h000007FF;
      20: v = 34'h000003FF;
      21: v = 34'h000001FF;
      22: v = 34'h000000FF;
      23: v = 34'h0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/tlik_sqrt.sv =====
module tlik_sqrt #(
  parameter int W  = 24,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_in,
  input  logic [2*W-1:0]  rad_in,
  input  logic [SW-1:0]   side_in,
  output logic            valid_out,
  output logic [W-1:0]    root_out,
  output logic [SW-1:0]   side_out
);
  localparam int RW = W + 3;

  logic            v_r    [W];
  logic [2*W-1:0]  rad_r  [W];
  logic [RW-1:0]   rem_r  [W];
  logic [W-1:0]    root_r [W];
  logic [SW-1:0]   side_r [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic            v_prev;
    logic [2*W-1:0]  rad_prev;
    logic [RW-1:0]   rem_prev;
    logic [W-1:0]    root_prev;
    logic [SW-1:0]   side_prev;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic [RW-1:0]   rem_nxt;
    logic [W-1:0]    root_nxt;

    if (i == 0) begin : g_first
      assign v_prev    = valid_in;
      assign rad_prev  = rad_in;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign side_prev = side_in;
    end else begin : g_next
      assign v_prev    = v_r[i-1];
      assign rad_prev  = rad_r[i-1];
      assign rem_prev  = rem_r[i-1];
      assign root_prev = root_r[i-1];
      assign side_prev = side_r[i-1];
    end

    // one result bit per stage, two radicand bits brought in
    always_comb begin
      rem_sh = {rem_prev[RW-3:0], rad_prev[2*W-1-2*i -: 2]};
      trial  = {1'b0, root_prev, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_prev[W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_prev[W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i]  <= rad_prev;
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        side_r[i] <= side_prev;
      end
    end
  end

  assign valid_out = v_r[W-1];
  assign root_out  = root_r[W-1];
  assign side_out  = side_r[W-1];

endmodule

// ===== hw/rtl/tlik_div.sv =====
module tlik_div #(
  parameter int DW = 56,
  parameter int VW = 40,
  parameter int QW = 15,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          valid_in,
  input  logic [DW-1:0] dividend_in,
  input  logic [VW-1:0] divisor_in,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [QW-1:0] quot_out,
  output logic [SW-1:0] side_out
);
  logic          v_r    [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [VW-1:0] dvs_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    localparam logic [QW-1:0] QBIT = QW'(1) << K;
    logic          v_prev;
    logic [DW-1:0] rem_prev;
    logic [VW-1:0] dvs_prev;
    logic [QW-1:0] q_prev;
    logic [SW-1:0] side_prev;
    logic [DW-1:0] cmp;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    if (j == 0) begin : g_first
      assign v_prev    = valid_in;
      assign rem_prev  = dividend_in;
      assign dvs_prev  = divisor_in;
      assign q_prev    = '0;
      assign side_prev = side_in;
    end else begin : g_next
      assign v_prev    = v_r[j-1];
      assign rem_prev  = rem_r[j-1];
      assign dvs_prev  = dvs_r[j-1];
      assign q_prev    = q_r[j-1];
      assign side_prev = side_r[j-1];
    end

    // restoring step, quotient bit K
    always_comb begin
      cmp = DW'(dvs_prev) << K;
      if (rem_prev >= cmp) begin
        rem_nxt = rem_prev - cmp;
        q_nxt   = q_prev | QBIT;
      end else begin
        rem_nxt = rem_prev;
        q_nxt   = q_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        dvs_r[j]  <= dvs_prev;
        q_r[j]    <= q_nxt;
        side_r[j] <= side_prev;
      end
    end
  end

  assign valid_out = v_r[QW-1];
  assign quot_out  = q_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

// ===== hw/rtl/tlik_cordic.sv =====
module tlik_cordic #(
  parameter int STEPS = tlik_pkg::CORDIC_STEPS_DEF,
  parameter int SW    = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic signed [tlik_pkg::XW-1:0] x_in,
  input  logic signed [tlik_pkg::XW-1:0] y_in,
  input  logic [SW-1:0]                 side_in,
  output logic                          valid_out,
  output logic signed [tlik_pkg::ZW-1:0] z_out,
  output logic [SW-1:0]                 side_out
);
  import tlik_pkg::*;

  logic                 pv_r;
  logic signed [XW-1:0] px_r, py_r;
  logic signed [ZW-1:0] pz_r;
  logic                 pzero_r;
  logic [SW-1:0]        pside_r;
  logic signed [XW-1:0] px_nxt, py_nxt;
  logic signed [ZW-1:0] pz_nxt;

  // quadrant fold for left half plane
  always_comb begin
    px_nxt = x_in;
    py_nxt = y_in;
    pz_nxt = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        px_nxt = y_in;
        py_nxt = -x_in;
        pz_nxt = PI_HALF_Q30;
      end else begin
        px_nxt = -y_in;
        py_nxt = x_in;
        pz_nxt = -PI_HALF_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
      pzero_r <= (x_in == 0) && (y_in == 0);
      pside_r <= side_in;
    end
  end

  logic                 v_r    [STEPS];
  logic signed [XW-1:0] x_r    [STEPS];
  logic signed [XW-1:0] y_r    [STEPS];
  logic signed [ZW-1:0] z_r    [STEPS];
  logic                 zero_r [STEPS];
  logic [SW-1:0]        side_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = $signed(atan_q30(i));
    logic                 v_prev;
    logic signed [XW-1:0] x_prev, y_prev;
    logic signed [ZW-1:0] z_prev;
    logic                 zero_prev;
    logic [SW-1:0]        side_prev;
    logic signed [XW-1:0] dx, dy;
    logic signed [XW-1:0] x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    if (i == 0) begin : g_first
      assign v_prev    = pv_r;
      assign x_prev    = px_r;
      assign y_prev    = py_r;
      assign z_prev    = pz_r;
      assign zero_prev = pzero_r;
      assign side_prev = pside_r;
    end else begin : g_next
      assign v_prev    = v_r[i-1];
      assign x_prev    = x_r[i-1];
      assign y_prev    = y_r[i-1];
      assign z_prev    = z_r[i-1];
      assign zero_prev = zero_r[i-1];
      assign side_prev = side_r[i-1];
    end

    always_comb begin
      dx = y_prev >>> i;
      dy = x_prev >>> i;
      if (y_prev >= 0) begin
        x_nxt = x_prev + dx;
        y_nxt = y_prev - dy;
        z_nxt = z_prev + ATAN;
      end else begin
        x_nxt = x_prev - dx;
        y_nxt = y_prev + dy;
        z_nxt = z_prev - ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        zero_r[i] <= zero_prev;
        side_r[i] <= side_prev;
      end
    end
  end

  // zero vector has angle zero
  assign valid_out = v_r[STEPS-1];
  assign z_out     = zero_r[STEPS-1] ? '0 : z_r[STEPS-1];
  assign side_out  = side_r[STEPS-1];

endmodule

// ===== hw/rtl/two_link_inverse_kinematics.sv =====
// two-link inverse kinematics pipeline
//
// input channel: in_valid / in_stall / in_data (target_x, target_y, Q12.4).
// result channel: out_valid / out_stall / out_data (angle_plus, angle_minus,
// out_of_reach), one result per input transaction, in input order.
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, always
// ready; index 0 first link, 1 second link, 2 angle scale, others ignored.
// write config only while no transaction is in flight.
//
// pipeline depth comes mostly from the two square root pipelines
// (24 and 15 stages), the 15-stage divider and the two parallel CORDIC
// pipelines.
// throughput: one transaction per cycle while no result is stalled.
// reset clears all valid bits and loads link lengths 0 and scale 1.0.
// a stalled result holds in the output register; the whole pipeline
// freezes and in_stall is raised only while that result is stalled.
module two_link_inverse_kinematics #(
  parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tlik_pkg::in_data_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tlik_pkg::out_data_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  tlik_pkg::cfg_index_t cfg_index,
  input  logic [31:0]          cfg_data
);
  import tlik_pkg::*;

  logic en;

  logic [14:0]        l1_r, l2_r;
  logic signed [31:0] scale_r;
  logic [29:0]        l1sq_r, l2sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r    <= '0;
      l2_r    <= '0;
      scale_r <= 32'sd65536;
      l1sq_r  <= '0;
      l2sq_r  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FIRST_LINK:  l1_r    <= cfg_data[14:0];
          CFG_SECOND_LINK: l2_r    <= cfg_data[14:0];
          CFG_ANGLE_SCALE: scale_r <= $signed(cfg_data);
          default: ;
        endcase
      end
      l1sq_r <= 30'(l1_r) * 30'(l1_r);
      l2sq_r <= 30'(l2_r) * 30'(l2_r);
    end
  end

  // stage 1: squared distance
  logic               s1_v_r;
  logic signed [15:0] s1_x_r, s1_y_r;
  logic [31:0]        s1_s_r;
  logic signed [31:0] sqx, sqy;

  assign sqx = in_data.target_x * in_data.target_x;
  assign sqy = in_data.target_y * in_data.target_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r <= in_data.target_x;
      s1_y_r <= in_data.target_y;
      s1_s_r <= $unsigned(sqx) + $unsigned(sqy);
    end
  end

  // stage 2: law of cosines numerator
  logic               s2_v_r;
  logic signed [15:0] s2_x_r, s2_y_r;
  logic [31:0]        s2_s_r;
  logic signed [33:0] s2_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x_r <= s1_x_r;
      s2_y_r <= s1_y_r;
      s2_s_r <= s1_s_r;
      s2_n_r <= $signed({4'b0, l1sq_r}) + $signed({2'b0, s1_s_r})
              - $signed({4'b0, l2sq_r});
    end
  end

  // distance root
  sq1_side_t  sq1_in, sq1_out;
  logic       sq1_v;
  logic [23:0] sq1_root;
  logic [$bits(sq1_side_t)-1:0] sq1_side_vec;

  always_comb begin
    sq1_in.x     = s2_x_r;
    sq1_in.y     = s2_y_r;
    sq1_in.n     = s2_n_r;
    sq1_in.szero = (s2_s_r == 0);
  end

  tlik_sqrt #(.W(24), .SW($bits(sq1_side_t))) u_sqrt_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (s2_v_r),
    .rad_in   ({s2_s_r, 16'b0}),
    .side_in  (sq1_in),
    .valid_out(sq1_v),
    .root_out (sq1_root),
    .side_out (sq1_side_vec)
  );

  assign sq1_out = sq1_side_t'(sq1_side_vec);

  // stage d: denominator and magnitude of numerator
  logic               sd_v_r;
  logic signed [15:0] sd_x_r, sd_y_r;
  logic [39:0]        sd_d_r;
  logic [32:0]        sd_an_r;
  logic               sd_szero_r, sd_npos_r, sd_nneg_r;
  logic [38:0]        l1c;
  logic [33:0]        nabs;

  assign l1c  = 39'(l1_r) * 39'(sq1_root);
  assign nabs = sq1_out.n[33] ? 34'(-sq1_out.n) : 34'(sq1_out.n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_v_r <= 1'b0;
    end else if (en) begin
      sd_v_r <= sq1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_x_r     <= sq1_out.x;
      sd_y_r     <= sq1_out.y;
      sd_d_r     <= {l1c, 1'b0};
      sd_an_r    <= nabs[32:0];
      sd_szero_r <= sq1_out.szero;
      sd_npos_r  <= !sq1_out.n[33] && (sq1_out.n != 0);
      sd_nneg_r  <= sq1_out.n[33];
    end
  end

  // stage b: reach check and rounded dividend
  logic        sb_v_r;
  div_side_t   sb_side_r;
  logic [55:0] sb_dvd_r;
  logic [39:0] sb_dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= 1'b0;
    end else if (en) begin
      sb_v_r <= sd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_side_r.x      <= sd_x_r;
      sb_side_r.y      <= sd_y_r;
      sb_side_r.szero  <= sd_szero_r;
      sb_side_r.dzero  <= (sd_d_r == 0);
      sb_side_r.beyond <= {sd_an_r, 8'b0} > {1'b0, sd_d_r};
      sb_side_r.npos   <= sd_npos_r;
      sb_side_r.nneg   <= sd_nneg_r;
      sb_dvd_r         <= 56'({sd_an_r, 22'b0}) + 56'(sd_d_r[39:1]);
      sb_dvs_r         <= sd_d_r;
    end
  end

  logic        dv_v;
  logic [14:0] dv_q;
  div_side_t   dv_out;
  logic [$bits(div_side_t)-1:0] dv_side_vec;

  tlik_div #(.DW(56), .VW(40), .QW(15), .SW($bits(div_side_t))) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .valid_in   (sb_v_r),
    .dividend_in(sb_dvd_r),
    .divisor_in (sb_dvs_r),
    .side_in    (sb_side_r),
    .valid_out  (dv_v),
    .quot_out   (dv_q),
    .side_out   (dv_side_vec)
  );

  assign dv_out = div_side_t'(dv_side_vec);

  // stage c: cosine select with clamping
  logic               sc_v_r;
  logic signed [15:0] sc_x_r, sc_y_r, sc_cos_r;
  logic               sc_flag_r;
  logic signed [15:0] cos_nxt;
  logic               flag_nxt;

  always_comb begin
    if (dv_out.szero) begin
      cos_nxt  = -ONE_Q14;
      flag_nxt = 1'b1;
    end else if (dv_out.dzero || dv_out.beyond) begin
      cos_nxt  = dv_out.npos ? ONE_Q14 : -ONE_Q14;
      flag_nxt = 1'b1;
    end else begin
      cos_nxt  = dv_out.nneg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
      flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
    end else if (en) begin
      sc_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_x_r    <= dv_out.x;
      sc_y_r    <= dv_out.y;
      sc_cos_r  <= cos_nxt;
      sc_flag_r <= flag_nxt;
    end
  end

  // stage q: 1 - cos^2
  logic               sq_v_r;
  sq2_side_t          sq_side_r;
  logic [29:0]        sq_rad_r;
  logic signed [31:0] csq;

  assign csq = sc_cos_r * sc_cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (en) begin
      sq_v_r <= sc_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r.x    <= sc_x_r;
      sq_side_r.y    <= sc_y_r;
      sq_side_r.cosv <= sc_cos_r;
      sq_side_r.flag <= sc_flag_r;
      sq_rad_r       <= {1'b0, 29'h1000_0000 - csq[28:0]};
    end
  end

  logic        sq2_v;
  logic [14:0] sin_v;
  sq2_side_t   sq2_out;
  logic [$bits(sq2_side_t)-1:0] sq2_side_vec;

  tlik_sqrt #(.W(15), .SW($bits(sq2_side_t))) u_sqrt_sin (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (sq_v_r),
    .rad_in   (sq_rad_r),
    .side_in  (sq_side_r),
    .valid_out(sq2_v),
    .root_out (sin_v),
    .side_out (sq2_side_vec)
  );

  assign sq2_out = sq2_side_t'(sq2_side_vec);

  // both angles in parallel lanes
  logic signed [XW-1:0] th_x, th_y, al_x, al_y;
  logic signed [ZW-1:0] th_z, al_z;
  logic                 th_v, al_v;
  logic [0:0]           th_flag, al_flag;

  assign th_x = {{4{sq2_out.x[15]}}, sq2_out.x, 16'b0};
  assign th_y = {{4{sq2_out.y[15]}}, sq2_out.y, 16'b0};
  assign al_x = {{4{sq2_out.cosv[15]}}, sq2_out.cosv, 16'b0};
  assign al_y = {5'b0, sin_v, 16'b0};

  tlik_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_cordic_theta (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (sq2_v),
    .x_in     (th_x),
    .y_in     (th_y),
    .side_in  (sq2_out.flag),
    .valid_out(th_v),
    .z_out    (th_z),
    .side_out (th_flag)
  );

  tlik_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_cordic_alpha (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (sq2_v),
    .x_in     (al_x),
    .y_in     (al_y),
    .side_in  (sq2_out.flag),
    .valid_out(al_v),
    .z_out    (al_z),
    .side_out (al_flag)
  );

  // stage z: round to Q4.12
  logic               sz_v_r;
  logic signed [16:0] sz_th_r, sz_al_r;
  logic               sz_flag_r;
  logic signed [34:0] th_rnd, al_rnd;

  assign th_rnd = 35'(th_z) - 35'(PI_HALF_Q30) + 35'sd131072;
  assign al_rnd = 35'(al_z) + 35'sd131072;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sz_v_r <= 1'b0;
    end else if (en) begin
      sz_v_r <= th_v && al_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sz_th_r   <= th_rnd[34:18];
      sz_al_r   <= al_rnd[34:18];
      sz_flag_r <= th_flag[0] | al_flag[0];
    end
  end

  // stage m: scale
  logic               sm_v_r;
  logic signed [49:0] sm_pp_r, sm_pm_r;
  logic               sm_flag_r;
  logic signed [17:0] phi_p, phi_m;

  assign phi_p = 18'(sz_th_r) + 18'(sz_al_r);
  assign phi_m = 18'(sz_th_r) - 18'(sz_al_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_v_r <= 1'b0;
    end else if (en) begin
      sm_v_r <= sz_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_pp_r   <= phi_p * scale_r;
      sm_pm_r   <= phi_m * scale_r;
      sm_flag_r <= sz_flag_r;
    end
  end

  // output register
  function automatic logic [31:0] round_sat(input logic signed [49:0] p);
    logic signed [50:0] s;
    logic signed [34:0] r;
    logic [31:0]        v;
    s = 51'(p) + 51'sd32768;
    r = s[50:16];
    if (r > 35'sd2147483647) begin
      v = 32'h7FFF_FFFF;
    end else if (r < -35'sd2147483648) begin
      v = 32'h8000_0000;
    end else begin
      v = r[31:0];
    end
    return v;
  endfunction

  logic      out_valid_r;
  out_data_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sm_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.angle_plus   <= $signed(round_sat(sm_pp_r));
      out_data_r.angle_minus  <= $signed(round_sat(sm_pm_r));
      out_data_r.out_of_reach <= sm_flag_r;
    end
  end

  // pipeline advances unless the held result is stalled
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/tlik_checker.sv =====
module tlik_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tlik_pkg::out_data_t out_data
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input backpressure only from a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_stall_need: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while pipeline frozen");

endmodule

bind two_link_inverse_kinematics tlik_checker u_tlik_checker (.*);
